// ===== rtl/alm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alm_pkg
// Opcodes and status codes shared by the linked list manager.
// ----------------------------------------------------------------------------
package alm_pkg;
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INS_BEFORE = 3'd1;
  localparam logic [2:0] OP_INS_AFTER = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_NEXT = 3'd4;
  localparam logic [2:0] OP_PREV = 3'd5;
  localparam logic [2:0] OP_READ = 3'd6;
  localparam logic [2:0] OP_INVALID = 3'd7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
endpackage
`default_nettype wire

// ===== rtl/alm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alm_ram
// Single write port, single registered read port memory.
// ----------------------------------------------------------------------------
module alm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/array_linked_list_manager_unit.sv =====
`default_nettype none
// Each request walks the states by opcode: rejected requests go straight to the
// result, next, previous and read pass through RD1 and RD2, inserts and remove
// pass through RD1, RD2, WA, WB and WC. One request is handled at a time; no new
// request is taken until the result is accepted.
// After reset a clearing pass over every slot chains the free list
// before the first request is taken.
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit
// Doubly linked list in slot memories with a singly linked free list.
// ----------------------------------------------------------------------------
module array_linked_list_manager_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [5:0]  slot,
  input  wire logic [31:0] payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [5:0]       result_slot,
  output logic [31:0]      result_payload,
  output logic [6:0]       entry_count
);
  import alm_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int LW = AW + 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD1, S_RD2, S_WA, S_WB, S_WC, S_OUT
  } state_t;

  state_t          state;
  logic [2:0]      op;
  logic [AW-1:0]   s, n;
  logic [DATA_WIDTH-1:0] din;
  logic [LW-1:0]   head, tail, fhead;
  logic [CW-1:0]   count;
  logic [SLOT_COUNT-1:0] live;
  logic [LW-1:0]   p, q, fnext;
  logic [AW-1:0]   init_idx;
  logic            slot_ok;

  logic            nx_we, pv_we, dt_we;
  logic [AW-1:0]   nx_wa, pv_wa, dt_wa, nx_ra, pv_ra, dt_ra;
  logic [LW-1:0]   nx_wd, pv_wd, nx_rd, pv_rd;
  logic [DATA_WIDTH-1:0] dt_rd;

  alm_ram #(.DEPTH(SLOT_COUNT), .WIDTH(LW)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  alm_ram #(.DEPTH(SLOT_COUNT), .WIDTH(LW)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  alm_ram #(.DEPTH(SLOT_COUNT), .WIDTH(DATA_WIDTH)) u_data (
    .clk(clk), .we(dt_we), .waddr(dt_wa), .wdata(din), .raddr(dt_ra), .rdata(dt_rd));

  assign in_ready = (state == S_IDLE);
  assign slot_ok = ({26'd0, slot} < 32'(SLOT_COUNT)) && live[AW'(slot)];
  assign nx_ra = (state == S_IDLE) ? AW'(slot) : (state == S_RD1 ? fhead[AW-1:0] : s);
  assign pv_ra = (state == S_IDLE) ? AW'(slot) : s;
  assign dt_ra = s;
  assign dt_we = (state == S_WA) && (op == OP_APPEND || op == OP_INS_BEFORE ||
                                     op == OP_INS_AFTER);
  assign dt_wa = n;

  // link writes per state
  always_comb begin
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    case (state)
      S_INIT: begin
        nx_we = 1'b1; nx_wa = init_idx;
        nx_wd = (init_idx == LAST) ? NIL : LW'(init_idx) + LW'(1);
      end
      S_WA: begin
        case (op)
          OP_APPEND: begin
            nx_we = 1'b1; nx_wa = n; nx_wd = NIL;
            pv_we = 1'b1; pv_wa = n; pv_wd = tail;
          end
          OP_INS_BEFORE: begin
            nx_we = 1'b1; nx_wa = n; nx_wd = {1'b0, s};
            pv_we = 1'b1; pv_wa = n; pv_wd = p;
          end
          OP_INS_AFTER: begin
            nx_we = 1'b1; nx_wa = n; nx_wd = q;
            pv_we = 1'b1; pv_wa = n; pv_wd = {1'b0, s};
          end
          OP_REMOVE: begin
            nx_we = !p[AW]; nx_wa = p[AW-1:0]; nx_wd = q;
            pv_we = !q[AW]; pv_wa = q[AW-1:0]; pv_wd = p;
          end
          default: ;
        endcase
      end
      S_WB: begin
        case (op)
          OP_APPEND: begin
            nx_we = !tail[AW]; nx_wa = tail[AW-1:0]; nx_wd = {1'b0, n};
          end
          OP_INS_BEFORE: begin
            nx_we = !p[AW]; nx_wa = p[AW-1:0]; nx_wd = {1'b0, n};
            pv_we = 1'b1; pv_wa = s; pv_wd = {1'b0, n};
          end
          OP_INS_AFTER: begin
            pv_we = !q[AW]; pv_wa = q[AW-1:0]; pv_wd = {1'b0, n};
            nx_we = 1'b1; nx_wa = s; nx_wd = {1'b0, n};
          end
          OP_REMOVE: begin
            nx_we = 1'b1; nx_wa = s; nx_wd = fhead;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT; init_idx <= '0; head <= NIL; tail <= NIL;
      fhead <= '0; count <= '0; live <= '0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          init_idx <= init_idx + AW'(1);
          if (init_idx == LAST) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op <= opcode; s <= AW'(slot); din <= DATA_WIDTH'(payload);
          result_slot <= '0; result_payload <= '0;
          if (opcode == OP_APPEND) begin
            if (fhead[AW]) begin status <= ST_FULL; state <= S_OUT; end
            else begin status <= ST_NONE; state <= S_RD1; end
          end else if (opcode == OP_INVALID || !slot_ok) begin
            status <= ST_NONE; state <= S_OUT;
          end else if ((opcode == OP_INS_BEFORE || opcode == OP_INS_AFTER) &&
                       fhead[AW]) begin
            status <= ST_FULL; state <= S_OUT;
          end else begin
            status <= ST_NONE; state <= S_RD1;
          end
        end
        S_RD1: begin
          p <= pv_rd; q <= nx_rd; n <= fhead[AW-1:0];
          state <= S_RD2;
        end
        S_RD2: begin
          fnext <= nx_rd;
          case (op)
            OP_NEXT: begin
              if (!q[AW]) begin status <= ST_OK; result_slot <= 6'(q[AW-1:0]); end
              state <= S_OUT;
            end
            OP_PREV: begin
              if (!p[AW]) begin status <= ST_OK; result_slot <= 6'(p[AW-1:0]); end
              state <= S_OUT;
            end
            OP_READ: begin
              status <= ST_OK; result_payload <= 32'(dt_rd); state <= S_OUT;
            end
            default: state <= S_WA;
          endcase
        end
        S_WA: state <= S_WB;
        S_WB: begin
          status <= ST_OK;
          case (op)
            OP_REMOVE: begin
              result_slot <= 6'(s);
              if (p[AW]) head <= q;
              if (q[AW]) tail <= p;
              fhead <= {1'b0, s}; live[s] <= 1'b0; count <= count - CW'(1);
            end
            default: begin
              result_slot <= 6'(n);
              fhead <= fnext; live[n] <= 1'b1; count <= count + CW'(1);
              if (op == OP_APPEND) begin
                tail <= {1'b0, n};
                if (head[AW]) head <= {1'b0, n};
              end else if (op == OP_INS_BEFORE) begin
                if (p[AW]) head <= {1'b0, n};
              end else if (q[AW]) tail <= {1'b0, n};
            end
          endcase
          state <= S_WC;
        end
        S_WC: state <= S_OUT;
        S_OUT: begin
          entry_count <= 7'(count);
          out_valid <= !(out_valid && out_ready);
          if (out_valid && out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== bench/array_linked_list_manager_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_linked_list_manager_unit_test
// Drives list operations into the linked list manager, mirrors the list,
// the free chain and the live count here, and compares every result.
// ----------------------------------------------------------------------------
module array_linked_list_manager_unit_test;
  import alm_pkg::*;

  localparam int NSLOT = 64;
  localparam int NIL = 127;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] data;
    logic [6:0]  count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  opcode = '0;
  logic [5:0]  slot = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  result_slot;
  logic [31:0] result_payload;
  logic [6:0]  entry_count;

  logic [6:0]  mdl_next [NSLOT];
  logic [6:0]  mdl_prev [NSLOT];
  logic [31:0] mdl_data [NSLOT];
  bit          mdl_live [NSLOT];
  logic [6:0]  mdl_head, mdl_tail, mdl_free;
  int          mdl_count;

  list_result_t expected_results[$];
  int  error_count = 0;
  int  result_count = 0;
  int  request_count = 0;
  int  idle_cycles = 0;
  int  sink_wait = 0;
  bit  hold_off = 1'b0;
  bit  sink_gaps = 1'b1;
  bit  src_gaps = 1'b1;

  array_linked_list_manager_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .slot(slot), .payload(payload),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_slot(result_slot),
    .result_payload(result_payload), .entry_count(entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_list();
    for (int i = 0; i < NSLOT; i++) begin
      mdl_next[i] = (i + 1 < NSLOT) ? 7'(i + 1) : 7'(NIL);
      mdl_prev[i] = 7'(NIL);
      mdl_data[i] = '0;
      mdl_live[i] = 1'b0;
    end
    mdl_head = 7'(NIL);
    mdl_tail = 7'(NIL);
    mdl_free = '0;
    mdl_count = 0;
  endfunction

  function automatic logic [6:0] claim_slot(logic [31:0] d);
    logic [6:0] n;
    n = mdl_free;
    mdl_free = mdl_next[n];
    mdl_data[n] = d;
    mdl_live[n] = 1'b1;
    mdl_count++;
    return n;
  endfunction

  function automatic list_result_t apply_op(logic [2:0] op, logic [5:0] s, logic [31:0] d);
    list_result_t r;
    logic [6:0] n, p, q;
    bit live;
    r = '0;
    r.status = ST_NONE;
    live = mdl_live[s];
    case (op)
      OP_APPEND: begin
        if (mdl_free == NIL) r.status = ST_FULL;
        else begin
          n = claim_slot(d);
          mdl_next[n] = 7'(NIL);
          mdl_prev[n] = mdl_tail;
          if (mdl_head == NIL) mdl_head = n;
          else mdl_next[mdl_tail] = n;
          mdl_tail = n;
          r.status = ST_OK;
          r.slot = n[5:0];
        end
      end
      OP_INS_BEFORE: begin
        if (live && mdl_free == NIL) r.status = ST_FULL;
        else if (live) begin
          n = claim_slot(d);
          p = mdl_prev[s];
          mdl_next[n] = 7'(s);
          mdl_prev[n] = p;
          if (p == NIL) mdl_head = n;
          else mdl_next[p] = n;
          mdl_prev[s] = n;
          r.status = ST_OK;
          r.slot = n[5:0];
        end
      end
      OP_INS_AFTER: begin
        if (live && mdl_free == NIL) r.status = ST_FULL;
        else if (live) begin
          n = claim_slot(d);
          q = mdl_next[s];
          mdl_prev[n] = 7'(s);
          mdl_next[n] = q;
          if (q == NIL) mdl_tail = n;
          else mdl_prev[q] = n;
          mdl_next[s] = n;
          r.status = ST_OK;
          r.slot = n[5:0];
        end
      end
      OP_REMOVE: begin
        if (live) begin
          p = mdl_prev[s];
          q = mdl_next[s];
          if (p == NIL) mdl_head = q;
          else mdl_next[p] = q;
          if (q == NIL) mdl_tail = p;
          else mdl_prev[q] = p;
          mdl_next[s] = mdl_free;
          mdl_free = 7'(s);
          mdl_live[s] = 1'b0;
          mdl_count--;
          r.status = ST_OK;
          r.slot = s;
        end
      end
      OP_NEXT: begin
        if (live && mdl_next[s] != NIL) begin
          r.status = ST_OK;
          r.slot = mdl_next[s][5:0];
        end
      end
      OP_PREV: begin
        if (live && mdl_prev[s] != NIL) begin
          r.status = ST_OK;
          r.slot = mdl_prev[s][5:0];
        end
      end
      OP_READ: begin
        if (live) begin
          r.status = ST_OK;
          r.data = mdl_data[s];
        end
      end
      default: ;
    endcase
    r.count = 7'(mdl_count);
    return r;
  endfunction

  function automatic logic [5:0] live_pick();
    int k;
    k = $urandom_range(0, NSLOT - 1);
    for (int i = 0; i < NSLOT; i++)
      if (mdl_live[(k + i) % NSLOT]) return 6'((k + i) % NSLOT);
    return 6'(k);
  endfunction

  task automatic send_request(logic [2:0] op, logic [5:0] s, logic [31:0] d);
    int g;
    g = src_gaps ? gap_len() : 0;
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    slot <= s;
    payload <= d;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_op(op, s, d));
    request_count++;
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_op(int full_bias);
    int r;
    logic [2:0] op;
    logic [5:0] s;
    r = $urandom_range(0, 99);
    if (r < full_bias) op = OP_APPEND;
    else op = 3'($urandom_range(0, 7));
    s = ($urandom_range(0, 9) < 8) ? live_pick() : 6'($urandom_range(0, 63));
    send_request(op, s, $urandom);
  endtask

  task automatic test_directed();
    send_request(OP_REMOVE, 6'd0, '0);
    send_request(OP_NEXT, 6'd63, '0);
    send_request(OP_INS_AFTER, 6'd5, 32'h1);
    send_request(OP_APPEND, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd0, 32'h0);
    send_request(OP_INS_BEFORE, 6'd0, 32'hA5A5_5A5A);
    send_request(OP_INS_AFTER, 6'd1, 32'h5A5A_A5A5);
    send_request(OP_PREV, 6'd2, '0);
    send_request(OP_NEXT, 6'd3, '0);
    send_request(OP_NEXT, 6'd3, '0);
    send_request(OP_PREV, 6'd1, '0);
    send_request(OP_READ, 6'd0, '0);
    send_request(OP_READ, 6'd1, '0);
    send_request(OP_INVALID, 6'd0, 32'hDEAD_BEEF);
    send_request(OP_REMOVE, 6'd2, '0);
    send_request(OP_REMOVE, 6'd3, '0);
    send_request(OP_REMOVE, 6'd0, '0);
    send_request(OP_REMOVE, 6'd0, '0);
    send_request(OP_PREV, 6'd1, '0);
    send_request(OP_REMOVE, 6'd1, '0);
    send_request(OP_READ, 6'd1, '0);
    wait_drained();
  endtask

  task automatic test_full_list();
    while (mdl_count < NSLOT) send_request(OP_APPEND, '0, $urandom);
    send_request(OP_APPEND, '0, $urandom);
    send_request(OP_INS_BEFORE, live_pick(), $urandom);
    send_request(OP_INS_AFTER, live_pick(), $urandom);
    send_request(OP_NEXT, mdl_tail[5:0], '0);
    send_request(OP_PREV, mdl_head[5:0], '0);
    while (mdl_count > 0) send_request(OP_REMOVE, live_pick(), '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    src_gaps = 1'b0;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (20) random_op(50);
    join
    src_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      random_op((i / 400) % 2 ? 70 : 30);
      if (i % 500 == 250) begin
        sink_gaps = ~sink_gaps;
        src_gaps = ~src_gaps;
      end
    end
    sink_gaps = 1'b1;
    src_gaps = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (out_valid && out_ready) begin
      sink_wait = sink_gaps ? gap_len() : 0;
      out_ready <= (sink_wait == 0);
    end else if (!out_ready) begin
      if (sink_wait > 0) sink_wait--;
      out_ready <= (sink_wait == 0);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d", $time, status, result_slot);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status || result_slot !== want.slot ||
            result_payload !== want.data || entry_count !== want.count) begin
          $display("%0t: mismatch expected st=%0d slot=%0d data=%h cnt=%0d", $time,
                   want.status, want.slot, want.data, want.count);
          $display("%0t:          actual   st=%0d slot=%0d data=%h cnt=%0d", $time,
                   status, result_slot, result_payload, entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d results pending", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    reset_list();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(2000);
    if (expected_results.size() != 0) error_count++;
    $display("Covered %0d requests and %0d results: all opcodes, full and empty list,",
             request_count, result_count);
    $display("neighbor ends, invalid slots and opcode, long output stall.");
    if (error_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/alm_pkg.sv
rtl/alm_ram.sv
rtl/array_linked_list_manager_unit.sv
bench/array_linked_list_manager_unit_test.sv
